// ===== hdl/tcp_pkg.sv =====
// Shared types and constants for the constant-pad index map.
package tcp_pkg;

    localparam int MAX_DIMS_DEF    = 6;
    localparam int SIZE_WIDTH_DEF  = 16;
    localparam int INDEX_WIDTH_DEF = 31;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int NUM_DESC = 6;
    localparam int DESC_W   = 48;
    localparam logic [DESC_W-1:0] DESC_RESET = 48'h0001_0000_0000;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FILL_CONST = 3'd6;

    typedef struct packed {
        logic valid;
        logic inv;
        logic pad;
    } t_ctl;

endpackage

// ===== hdl/tcp_cfg.sv =====
// Register file and stride/count derivation sequencer.
module tcp_cfg #(
    parameter int MAX_DIMS    = tcp_pkg::MAX_DIMS_DEF,
    parameter int SIZE_WIDTH  = tcp_pkg::SIZE_WIDTH_DEF,
    parameter int INDEX_WIDTH = tcp_pkg::INDEX_WIDTH_DEF,
    parameter int DATA_WIDTH  = tcp_pkg::DATA_WIDTH_DEF,
    parameter int QW          = SIZE_WIDTH + 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tcp_pkg::APB_AW-1:0]             paddr,
    input  logic [tcp_pkg::APB_DW-1:0]             pwdata,
    output logic [tcp_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready,
    output logic                                   o_busy,
    output logic                                   o_overflow,
    output logic [INDEX_WIDTH-1:0]                 o_total,
    output logic [DATA_WIDTH-1:0]                  o_fill_const,
    output logic [MAX_DIMS-1:0][SIZE_WIDTH-1:0]    o_before,
    output logic [MAX_DIMS-1:0][SIZE_WIDTH-1:0]    o_size,
    output logic [MAX_DIMS-1:0][INDEX_WIDTH:0]     o_ostride,
    output logic [MAX_DIMS-1:0][INDEX_WIDTH:0]     o_istride
);
    localparam int IW     = INDEX_WIDTH;
    localparam int SW     = SIZE_WIDTH;
    localparam int EXT_W  = (3*SW > tcp_pkg::DESC_W) ? 3*SW : tcp_pkg::DESC_W;
    localparam int STEP_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PW     = IW + 1 + QW;

    logic [tcp_pkg::NUM_DESC-1:0][tcp_pkg::DESC_W-1:0] r_desc;
    logic [DATA_WIDTH-1:0]         r_pad;
    logic                          r_busy;
    logic [STEP_W-1:0]             r_step;
    logic                          r_overflow;
    logic [IW-1:0]                 r_total;
    logic [MAX_DIMS-1:0][IW:0]     r_ostride;
    logic [MAX_DIMS-1:0][IW:0]     r_istride;
    logic [MAX_DIMS-1:0][QW-1:0]   osize;
    logic [tcp_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr;
    logic                          desc_wr;
    logic [IW:0]                   mul_o;
    logic [IW:0]                   mul_i;

    function automatic logic [IW:0] f_mul_sat(input logic [IW:0] a, input logic [QW-1:0] b);
        logic [PW-1:0] p;
        p = PW'(a) * PW'(b);
        if (p > PW'({IW{1'b1}})) begin
            return {1'b1, {IW{1'b0}}};
        end
        return p[IW:0];
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = paddr[tcp_pkg::APB_AW-1:3];
    assign wr      = psel && penable && pwrite;
    assign desc_wr = wr && (reg_idx < tcp_pkg::REG_IDX_W'(tcp_pkg::NUM_DESC));

    always_comb begin
        prdata = '0;
        if (reg_idx < tcp_pkg::REG_IDX_W'(tcp_pkg::NUM_DESC)) begin
            prdata = tcp_pkg::APB_DW'(r_desc[reg_idx]);
        end else if (reg_idx == tcp_pkg::REG_FILL_CONST) begin
            prdata = tcp_pkg::APB_DW'(r_pad);
        end
    end

    genvar d;
    generate
        for (d = 0; d < MAX_DIMS; d++) begin : g_dim
            logic [EXT_W-1:0] ext;
            if (d < tcp_pkg::NUM_DESC) begin : g_reg
                assign ext = EXT_W'(r_desc[d]);
            end else begin : g_fix
                assign ext = EXT_W'(tcp_pkg::DESC_RESET);
            end
            assign o_before[d] = ext[SW-1:0];
            assign o_size[d]   = ext[3*SW-1:2*SW];
            assign osize[d]    = QW'(ext[SW-1:0]) + QW'(ext[2*SW-1:SW]) + QW'(ext[3*SW-1:2*SW]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tcp_pkg::NUM_DESC; k++) begin
                r_desc[k] <= tcp_pkg::DESC_RESET;
            end
            r_pad <= '0;
        end else if (wr) begin
            if (desc_wr) begin
                r_desc[reg_idx] <= pwdata[tcp_pkg::DESC_W-1:0];
            end else if (reg_idx == tcp_pkg::REG_FILL_CONST) begin
                r_pad <= pwdata[DATA_WIDTH-1:0];
            end
        end
    end

    // one stride pair per cycle, innermost outward; the last product is the count
    assign mul_o = f_mul_sat(r_ostride[r_step], osize[r_step]);
    assign mul_i = f_mul_sat(r_istride[r_step], QW'(o_size[r_step]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_step     <= STEP_W'(MAX_DIMS-1);
            r_overflow <= 1'b0;
        end else if (desc_wr) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(MAX_DIMS-1);
        end else if (r_busy) begin
            if (r_step != '0) begin
                r_step <= r_step - 1'b1;
            end else begin
                r_busy     <= 1'b0;
                r_overflow <= mul_o[IW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostride[MAX_DIMS-1] <= (IW+1)'(1);
        r_istride[MAX_DIMS-1] <= (IW+1)'(1);
        if (r_busy && !desc_wr) begin
            if (r_step != '0) begin
                r_ostride[r_step - 1'b1] <= mul_o;
                r_istride[r_step - 1'b1] <= mul_i;
            end else begin
                r_total <= mul_o[IW] ? '0 : mul_o[IW-1:0];
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_overflow   = r_overflow;
    assign o_total      = r_total;
    assign o_fill_const = r_pad;
    assign o_ostride    = r_ostride;
    assign o_istride    = r_istride;

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_wr |=> r_busy) else $error("descriptor write did not start derivation");
    a_ovf_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_overflow && !r_busy) |-> (r_total == '0)) else $error("overflow with nonzero count");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_W'(MAX_DIMS-1))) else $error("derivation step out of range");

endmodule

// ===== hdl/tcp_div_cell.sv =====
// One quotient-bit step of the restoring coordinate division.
module tcp_div_cell #(
    parameter int IW  = tcp_pkg::INDEX_WIDTH_DEF,
    parameter int QW  = tcp_pkg::SIZE_WIDTH_DEF + 2,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  tcp_pkg::t_ctl i_ctl,
    input  logic [IW-1:0] i_idx,
    input  logic [IW-1:0] i_rem,
    input  logic [QW-1:0] i_q,
    input  logic [IW-1:0] i_src,
    input  logic [IW-1:0] i_prod,
    input  logic [IW:0]   i_stride,
    output tcp_pkg::t_ctl o_ctl,
    output logic [IW-1:0] o_idx,
    output logic [IW-1:0] o_rem,
    output logic [QW-1:0] o_q,
    output logic [IW-1:0] o_src,
    output logic [IW-1:0] o_prod
);
    localparam int TW = IW + QW + 1;

    tcp_pkg::t_ctl r_ctl;
    logic [IW-1:0] r_idx, r_rem, r_src, r_prod;
    logic [QW-1:0] r_q;
    logic [TW-1:0] trial;
    logic          ge;

    assign trial = TW'(i_stride) << BIT;
    assign ge    = {{(TW-IW){1'b0}}, i_rem} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx  <= i_idx;
            r_rem  <= ge ? (i_rem - trial[IW-1:0]) : i_rem;
            r_q    <= ge ? (i_q | (QW'(1) << BIT)) : i_q;
            r_src  <= i_src;
            r_prod <= i_prod;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_idx  = r_idx;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_src  = r_src;
    assign o_prod = r_prod;

endmodule

// ===== hdl/tcp_dim_cell.sv =====
// End of one dimension: pad band check and source offset term.
module tcp_dim_cell #(
    parameter int IW = tcp_pkg::INDEX_WIDTH_DEF,
    parameter int SW = tcp_pkg::SIZE_WIDTH_DEF,
    parameter int QW = tcp_pkg::SIZE_WIDTH_DEF + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  tcp_pkg::t_ctl i_ctl,
    input  logic [IW-1:0] i_idx,
    input  logic [IW-1:0] i_rem,
    input  logic [QW-1:0] i_coord,
    input  logic [IW-1:0] i_src,
    input  logic [IW-1:0] i_prod,
    input  logic [SW-1:0] i_before,
    input  logic [SW-1:0] i_size,
    input  logic [IW:0]   i_istride,
    output tcp_pkg::t_ctl o_ctl,
    output logic [IW-1:0] o_idx,
    output logic [IW-1:0] o_rem,
    output logic [IW-1:0] o_src,
    output logic [IW-1:0] o_prod
);
    localparam int MW = QW + IW;

    tcp_pkg::t_ctl r_ctl;
    logic [IW-1:0] r_idx, r_rem, r_src, r_prod;
    logic          in_band;
    logic [QW-1:0] offs;
    logic [MW-1:0] term;
    tcp_pkg::t_ctl ctl_n;

    assign in_band = (i_coord >= QW'(i_before)) &&
                     (i_coord < (QW'(i_before) + QW'(i_size)));
    assign offs    = i_coord - QW'(i_before);
    assign term    = MW'(offs) * MW'(i_istride[IW-1:0]);

    always_comb begin
        ctl_n     = i_ctl;
        ctl_n.pad = i_ctl.pad || !in_band;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= ctl_n;
        end
    end

    // previous dimension's term is folded in here, this one's in the next dimension cell or the output sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx  <= i_idx;
            r_rem  <= i_rem;
            r_src  <= i_src + i_prod;
            r_prod <= term[IW-1:0];
        end
    end

    assign o_ctl  = r_ctl;
    assign o_idx  = r_idx;
    assign o_rem  = r_rem;
    assign o_src  = r_src;
    assign o_prod = r_prod;

endmodule

// ===== hdl/tensor_constant_pad_index_map.sv =====
// Throughput: one transaction per cycle while the output queue is not full and no
// derivation runs; each dimension is a chain of SIZE_WIDTH+2 restoring-division
// cells plus one band-check cell, with a two-entry output queue.
// After reset and after each descriptor write, stride derivation runs with input
// ready low. Reset restores descriptors to size 1, no padding, pad value 0.
module tensor_constant_pad_index_map #(
    parameter int MAX_DIMS    = tcp_pkg::MAX_DIMS_DEF,
    parameter int SIZE_WIDTH  = tcp_pkg::SIZE_WIDTH_DEF,
    parameter int INDEX_WIDTH = tcp_pkg::INDEX_WIDTH_DEF,
    parameter int DATA_WIDTH  = tcp_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [INDEX_WIDTH-1:0]       i_out_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_valid_res,
    output logic                         o_is_pad,
    output logic [INDEX_WIDTH-1:0]       o_src_index,
    output logic [INDEX_WIDTH-1:0]       o_dst_index,
    output logic [DATA_WIDTH-1:0]        o_fill_value,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcp_pkg::APB_AW-1:0]   paddr,
    input  logic [tcp_pkg::APB_DW-1:0]   pwdata,
    output logic [tcp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    localparam int IW = INDEX_WIDTH;
    localparam int SW = SIZE_WIDTH;
    localparam int QW = SIZE_WIDTH + 2;
    localparam int N  = MAX_DIMS * (QW + 1);

    logic                       busy, overflow;
    logic [IW-1:0]              total;
    logic [DATA_WIDTH-1:0]      fill_const;
    logic [MAX_DIMS-1:0][SW-1:0] pad_bef, size;
    logic [MAX_DIMS-1:0][IW:0]  ostride, istride;

    tcp_cfg #(
        .MAX_DIMS(MAX_DIMS), .SIZE_WIDTH(SIZE_WIDTH),
        .INDEX_WIDTH(INDEX_WIDTH), .DATA_WIDTH(DATA_WIDTH), .QW(QW)
    ) u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_busy(busy), .o_overflow(overflow), .o_total(total), .o_fill_const(fill_const),
        .o_before(pad_bef), .o_size(size), .o_ostride(ostride), .o_istride(istride)
    );

    tcp_pkg::t_ctl w_ctl [N+1];
    logic [IW-1:0] w_idx [N+1];
    logic [IW-1:0] w_rem [N+1];
    logic [IW-1:0] w_src [N+1];
    logic [IW-1:0] w_prod[N+1];
    logic [QW-1:0] w_q   [N+1];

    logic       adv;
    logic [1:0] r_cnt;
    logic       r_wr, r_rd;
    logic       push, pop;
    logic [IW-1:0] src_f;

    assign adv        = (r_cnt != 2'd2);
    assign o_in_ready = adv && !busy;

    assign w_ctl[0].valid = i_in_valid && !busy;
    assign w_ctl[0].inv   = overflow || (i_out_index >= total);
    assign w_ctl[0].pad   = 1'b0;
    assign w_idx[0]  = i_out_index;
    assign w_rem[0]  = i_out_index;
    assign w_src[0]  = '0;
    assign w_prod[0] = '0;
    assign w_q[0]    = '0;

    genvar d, b;
    generate
        for (d = 0; d < MAX_DIMS; d++) begin : g_dim
            for (b = 0; b < QW; b++) begin : g_bit
                localparam int P = d*(QW+1) + b;
                tcp_div_cell #(.IW(IW), .QW(QW), .BIT(QW-1-b)) u_div (
                    .i_clk, .i_rst_n, .i_en(adv),
                    .i_ctl(w_ctl[P]), .i_idx(w_idx[P]), .i_rem(w_rem[P]), .i_q(w_q[P]),
                    .i_src(w_src[P]), .i_prod(w_prod[P]), .i_stride(ostride[d]),
                    .o_ctl(w_ctl[P+1]), .o_idx(w_idx[P+1]), .o_rem(w_rem[P+1]),
                    .o_q(w_q[P+1]), .o_src(w_src[P+1]), .o_prod(w_prod[P+1])
                );
            end
            localparam int E = d*(QW+1) + QW;
            tcp_dim_cell #(.IW(IW), .SW(SW), .QW(QW)) u_dim (
                .i_clk, .i_rst_n, .i_en(adv),
                .i_ctl(w_ctl[E]), .i_idx(w_idx[E]), .i_rem(w_rem[E]), .i_coord(w_q[E]),
                .i_src(w_src[E]), .i_prod(w_prod[E]), .i_before(pad_bef[d]),
                .i_size(size[d]), .i_istride(istride[d]),
                .o_ctl(w_ctl[E+1]), .o_idx(w_idx[E+1]), .o_rem(w_rem[E+1]),
                .o_src(w_src[E+1]), .o_prod(w_prod[E+1])
            );
            assign w_q[E+1] = '0;
        end
    endgenerate

    // output queue: the pipe keeps moving while one result waits
    logic                  r_q_vres [2];
    logic                  r_q_pad  [2];
    logic [IW-1:0]         r_q_src  [2];
    logic [IW-1:0]         r_q_dst  [2];
    logic [DATA_WIDTH-1:0] r_q_fill [2];
    logic                  ok, is_pad;

    assign push   = adv && w_ctl[N].valid;
    assign pop    = o_out_valid && i_out_ready;
    assign src_f  = w_src[N] + w_prod[N];
    assign ok     = !w_ctl[N].inv;
    assign is_pad = ok && w_ctl[N].pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_vres[r_wr] <= ok;
            r_q_pad[r_wr]  <= is_pad;
            r_q_src[r_wr]  <= (ok && !w_ctl[N].pad) ? src_f : '0;
            r_q_dst[r_wr]  <= w_idx[N];
            r_q_fill[r_wr] <= is_pad ? fill_const : '0;
        end
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_valid_res  = r_q_vres[r_rd];
    assign o_is_pad     = r_q_pad[r_rd];
    assign o_src_index  = r_q_src[r_rd];
    assign o_dst_index  = r_q_dst[r_rd];
    assign o_fill_value = r_q_fill[r_rd];

    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_in_ready) else $error("input accepted during derivation");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output queue count out of range");
    a_cnt_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 2'd1)) else $error("queue count slip");

endmodule
